// ===== rtl/sstws_pkg.sv =====
package sstws_pkg;

    // Largest number of segment bytes sent in one data frame.
    localparam int unsigned MAX_DIGITS = 4;

    localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
    localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY    = 8'h80;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_BEGIN = 1'b1;

    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_ENABLE     = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] digit0_segments;
        logic [7:0] digit1_segments;
        logic [7:0] digit2_segments;
        logic [7:0] digit3_segments;
        logic [2:0] digit_count;
        logic [1:0] start_digit;
        logic       dio_sense;
    } t_in_item;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic busy_res;
        logic done_res;
        logic ack_missing;
    } t_out_item;

endpackage

// ===== rtl/seven_segment_two_wire_sender.sv =====
// Channel   Direction  Handshake                     Payload
// in        in         i_in_valid / o_in_stall       i_in_data   (t_in_item)
// out       out        o_out_valid / i_out_stall     o_out_data  (t_out_item)
// cfg       in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// Every input beat gives exactly one output beat, in the cycle after it is accepted.
// A new beat is accepted in every cycle unless the input stalls; the single output register sets that figure.
// The input stalls only while the output register is full and the output is stalled.
// Reset (i_rst_n low, synchronous) idles both lines high and restores the register defaults.
// Configuration writes are always taken and land in the next cycle.
module seven_segment_two_wire_sender
    import sstws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [2:0] i_cfg_data
);

    // One phase of the sequence is advanced by each tick beat; a tick while idle leaves it idle.
    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_BIT_A, PH_BIT_B, PH_BIT_C,
        PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4,
        PH_STOP1, PH_STOP2, PH_STOP3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [1:0] r_frame_index, n_frame_index;
    logic [2:0] r_byte_index, n_byte_index;
    logic [2:0] r_bit_index, n_bit_index;
    logic [7:0] r_shift_byte, n_shift_byte;
    logic [2:0] r_bytes_to_send, n_bytes_to_send;
    logic [1:0] r_address_offset, n_address_offset;
    logic       r_clk_line, n_clk_line;
    logic       r_dio_line, n_dio_line;
    logic       r_nack, n_nack;
    logic [2:0] r_brightness;
    logic       r_enable;
    logic [7:0] r_store [MAX_DIGITS];
    logic       r_out_valid;
    t_out_item  r_out_data;
    t_out_item  n_out_data;
    logic       w_accept;
    logic       w_load_store;
    logic       w_done;
    logic [2:0] w_count;
    logic [2:0] w_load_index;

    // Byte sent in the current frame slot. The data bytes follow the address byte,
    // so data byte k sits at slot k + 1.
    function automatic logic [7:0] slot_byte(
        input logic [1:0] frame,
        input logic [2:0] slot
    );
        logic [2:0] data_index;
        data_index = slot - 3'd1;
        slot_byte  = 8'h00;
        if (frame == 2'd0) begin
            slot_byte = CMD_DATA_WRITE;
        end else if (frame == 2'd1) begin
            if (slot == 3'd0) begin
                slot_byte = CMD_ADDRESS + {6'd0, r_address_offset};
            end else if (32'(data_index) < MAX_DIGITS) begin
                slot_byte = r_store[data_index[1:0]];
            end
        end else begin
            slot_byte = CMD_DISPLAY + {4'd0, r_enable, r_brightness};
        end
    endfunction

    // The output register frees itself whenever the far side is not stalling.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    // A count beyond the store depth is clipped to it.
    assign w_count = (32'(i_in_data.digit_count) > MAX_DIGITS)
                   ? 3'(MAX_DIGITS) : i_in_data.digit_count;

    always_comb begin
        n_phase          = r_phase;
        n_frame_index    = r_frame_index;
        n_byte_index     = r_byte_index;
        n_bit_index      = r_bit_index;
        n_shift_byte     = r_shift_byte;
        n_bytes_to_send  = r_bytes_to_send;
        n_address_offset = r_address_offset;
        n_clk_line       = r_clk_line;
        n_dio_line       = r_dio_line;
        n_nack           = r_nack;
        w_done           = 1'b0;
        w_load_store     = 1'b0;
        w_load_index     = r_byte_index + 3'd1;

        if (i_in_data.opcode == OP_BEGIN) begin
            // A begin beat while a transfer runs leaves the sequence unchanged.
            if (r_phase == PH_IDLE) begin
                w_load_store     = 1'b1;
                n_bytes_to_send  = w_count;
                n_address_offset = i_in_data.start_digit;
                n_frame_index    = 2'd0;
                n_byte_index     = 3'd0;
                n_bit_index      = 3'd0;
                n_nack           = 1'b0;
                n_phase          = PH_START;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_START: begin
                    n_dio_line   = 1'b0;
                    n_byte_index = 3'd0;
                    n_bit_index  = 3'd0;
                    n_shift_byte = slot_byte(r_frame_index, 3'd0);
                    n_phase      = PH_BIT_A;
                end
                PH_BIT_A: begin
                    n_clk_line = 1'b0;
                    n_phase    = PH_BIT_B;
                end
                PH_BIT_B: begin
                    n_dio_line = r_shift_byte[0];
                    n_phase    = PH_BIT_C;
                end
                PH_BIT_C: begin
                    n_clk_line   = 1'b1;
                    n_shift_byte = {1'b0, r_shift_byte[7:1]};
                    if (r_bit_index == 3'd7) begin
                        n_bit_index = 3'd0;
                        n_phase     = PH_ACK1;
                    end else begin
                        n_bit_index = r_bit_index + 3'd1;
                        n_phase     = PH_BIT_A;
                    end
                end
                PH_ACK1: begin
                    n_clk_line = 1'b0;
                    n_dio_line = 1'b1;
                    n_phase    = PH_ACK2;
                end
                PH_ACK2: begin
                    n_clk_line = 1'b1;
                    n_phase    = PH_ACK3;
                end
                PH_ACK3: begin
                    if (!i_in_data.dio_sense) begin
                        n_dio_line = 1'b0;
                    end else begin
                        n_nack = 1'b1;
                    end
                    n_phase = PH_ACK4;
                end
                PH_ACK4: begin
                    n_clk_line = 1'b0;
                    if (r_frame_index == 2'd1 && r_byte_index < r_bytes_to_send) begin
                        n_byte_index = w_load_index;
                        n_shift_byte = slot_byte(r_frame_index, w_load_index);
                        n_phase      = PH_BIT_A;
                    end else begin
                        n_phase = PH_STOP1;
                    end
                end
                PH_STOP1: begin
                    n_dio_line = 1'b0;
                    n_phase    = PH_STOP2;
                end
                PH_STOP2: begin
                    n_clk_line = 1'b1;
                    n_phase    = PH_STOP3;
                end
                PH_STOP3: begin
                    n_dio_line = 1'b1;
                    if (r_frame_index >= 2'd2) begin
                        n_frame_index = 2'd0;
                        w_done        = 1'b1;
                        n_phase       = PH_IDLE;
                    end else begin
                        n_frame_index = r_frame_index + 2'd1;
                        n_phase       = PH_START;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        n_out_data.clk_level   = n_clk_line;
        n_out_data.dio_level   = n_dio_line;
        n_out_data.busy_res    = (n_phase != PH_IDLE) || w_done;
        n_out_data.done_res    = w_done;
        n_out_data.ack_missing = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_frame_index    <= 2'd0;
            r_byte_index     <= 3'd0;
            r_bit_index      <= 3'd0;
            r_shift_byte     <= 8'h00;
            r_bytes_to_send  <= 3'd0;
            r_address_offset <= 2'd0;
            r_clk_line       <= 1'b1;
            r_dio_line       <= 1'b1;
            r_nack           <= 1'b0;
            r_brightness     <= 3'd7;
            r_enable         <= 1'b1;
            r_out_valid      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase          <= n_phase;
                r_frame_index    <= n_frame_index;
                r_byte_index     <= n_byte_index;
                r_bit_index      <= n_bit_index;
                r_shift_byte     <= n_shift_byte;
                r_bytes_to_send  <= n_bytes_to_send;
                r_address_offset <= n_address_offset;
                r_clk_line       <= n_clk_line;
                r_dio_line       <= n_dio_line;
                r_nack           <= n_nack;
                r_out_valid      <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_BRIGHTNESS: r_brightness <= i_cfg_data;
                    REG_ENABLE:     r_enable     <= i_cfg_data[0];
                endcase
            end
        end
    end

    // Payload registers: the segment store and the result beat carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
            if (w_load_store) begin
                r_store[0] <= i_in_data.digit0_segments;
                r_store[1] <= i_in_data.digit1_segments;
                r_store[2] <= i_in_data.digit2_segments;
                r_store[3] <= i_in_data.digit3_segments;
            end
        end
    end

    // Between transfers both lines rest high.
    a_idle_lines_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_clk_line && r_dio_line)
        else $error("lines not high while idle");

    // The data-byte counter never runs past the latched count.
    a_byte_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= r_bytes_to_send)
        else $error("byte index beyond byte count");

    // Only three frames exist.
    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_index != 2'd3)
        else $error("frame index out of range");

    // A finishing beat ends the transfer and leaves the lines idle.
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_done |=> r_phase == PH_IDLE && o_out_data.busy_res
            && o_out_data.clk_level && o_out_data.dio_level)
        else $error("done beat did not end the transfer");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import sstws_pkg::*;

    // Generous ceiling on the run: an update is at most a few hundred beats,
    // and each beat may wait out sender gaps and receiver stalls.
    localparam int CYCLE_LIMIT = 400000;
    // Non-ignored input beats wanted before the random part stops.
    localparam int BEAT_GOAL = 850;

    // Bit-delay phases of the two-wire sequence, in the order they are walked.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_BIT_LOW,
        ST_BIT_SET,
        ST_BIT_HIGH,
        ST_ACK_RELEASE,
        ST_ACK_CLOCK,
        ST_ACK_SAMPLE,
        ST_ACK_END,
        ST_STOP_LOW,
        ST_STOP_CLOCK,
        ST_STOP_RELEASE
    } t_link_phase;

    // How the display answers in the acknowledge slots of one update.
    typedef enum int {
        ACK_ALWAYS,
        ACK_NEVER,
        ACK_RANDOM,
        ACK_MOSTLY
    } t_ack_style;

    // Tracks the line levels the sender ought to produce. Every accepted input
    // beat is stepped through a private copy of the sequence, and the levels it
    // leaves behind are queued until the matching output beat turns up.
    class t_link_tracker;
        t_link_phase phase;
        logic [1:0]  frame_no;
        logic [2:0]  byte_no;
        logic [2:0]  bit_no;
        logic [7:0]  shifter;
        logic [7:0]  segments [MAX_DIGITS];
        logic [2:0]  byte_total;
        logic [1:0]  position;
        logic        clk_line;
        logic        dio_line;
        logic        nack;
        logic [2:0]  brightness;
        logic        enable;
        t_out_item   levels_due [$];
        int          fault_count;
        int          useful_beats;
        int          ignored_beats;
        int          updates_done;
        int          nack_updates;

        function new();
            brightness = 3'd7;
            enable = 1'b1;
            phase = ST_IDLE;
            frame_no = '0;
            byte_no = '0;
            bit_no = '0;
            shifter = '0;
            byte_total = '0;
            position = '0;
            clk_line = 1'b1;
            dio_line = 1'b1;
            nack = 1'b0;
            foreach (segments[i]) segments[i] = '0;
            fault_count = 0;
            useful_beats = 0;
            ignored_beats = 0;
            updates_done = 0;
            nack_updates = 0;
        endfunction

        function void set_register(logic index, logic [2:0] value);
            if (index == REG_BRIGHTNESS) begin
                brightness = value;
            end else begin
                enable = value[0];
            end
        endfunction

        function bit busy();
            return phase != ST_IDLE;
        endfunction

        // Byte that belongs in the current slot of the current frame.
        function logic [7:0] slot_byte();
            if (frame_no == 2'd0) begin
                return CMD_DATA_WRITE;
            end
            if (frame_no == 2'd1) begin
                if (byte_no == 3'd0) begin
                    return CMD_ADDRESS + {6'd0, position};
                end
                return segments[2'(byte_no - 3'd1)];
            end
            return CMD_DISPLAY + {4'd0, enable, brightness};
        endfunction

        function void note_beat(t_in_item beat);
            t_out_item lv;
            logic      finished;
            finished = 1'b0;
            if (beat.opcode == OP_BEGIN) begin
                if (phase == ST_IDLE) begin
                    segments[0] = beat.digit0_segments;
                    segments[1] = beat.digit1_segments;
                    segments[2] = beat.digit2_segments;
                    segments[3] = beat.digit3_segments;
                    byte_total = (beat.digit_count > MAX_DIGITS) ?
                                 3'(MAX_DIGITS) : beat.digit_count;
                    position = beat.start_digit;
                    frame_no = '0;
                    byte_no = '0;
                    bit_no = '0;
                    nack = 1'b0;
                    phase = ST_START;
                    useful_beats++;
                end else begin
                    ignored_beats++;
                end
            end else begin
                if (phase == ST_IDLE) begin
                    ignored_beats++;
                end else begin
                    useful_beats++;
                end
                case (phase)
                    ST_START: begin
                        dio_line = 1'b0;
                        byte_no = '0;
                        bit_no = '0;
                        shifter = slot_byte();
                        phase = ST_BIT_LOW;
                    end
                    ST_BIT_LOW: begin
                        clk_line = 1'b0;
                        phase = ST_BIT_SET;
                    end
                    ST_BIT_SET: begin
                        dio_line = shifter[0];
                        phase = ST_BIT_HIGH;
                    end
                    ST_BIT_HIGH: begin
                        clk_line = 1'b1;
                        shifter = shifter >> 1;
                        if (bit_no >= 3'd7) begin
                            bit_no = '0;
                            phase = ST_ACK_RELEASE;
                        end else begin
                            bit_no = bit_no + 3'd1;
                            phase = ST_BIT_LOW;
                        end
                    end
                    ST_ACK_RELEASE: begin
                        clk_line = 1'b0;
                        dio_line = 1'b1;
                        phase = ST_ACK_CLOCK;
                    end
                    ST_ACK_CLOCK: begin
                        clk_line = 1'b1;
                        phase = ST_ACK_SAMPLE;
                    end
                    ST_ACK_SAMPLE: begin
                        if (!beat.dio_sense) begin
                            dio_line = 1'b0;
                        end else begin
                            nack = 1'b1;
                        end
                        phase = ST_ACK_END;
                    end
                    ST_ACK_END: begin
                        clk_line = 1'b0;
                        if (frame_no == 2'd1 && byte_no < byte_total) begin
                            byte_no = byte_no + 3'd1;
                            shifter = slot_byte();
                            phase = ST_BIT_LOW;
                        end else begin
                            phase = ST_STOP_LOW;
                        end
                    end
                    ST_STOP_LOW: begin
                        dio_line = 1'b0;
                        phase = ST_STOP_CLOCK;
                    end
                    ST_STOP_CLOCK: begin
                        clk_line = 1'b1;
                        phase = ST_STOP_RELEASE;
                    end
                    ST_STOP_RELEASE: begin
                        dio_line = 1'b1;
                        if (frame_no >= 2'd2) begin
                            frame_no = '0;
                            finished = 1'b1;
                            phase = ST_IDLE;
                            updates_done++;
                            if (nack) nack_updates++;
                        end else begin
                            frame_no = frame_no + 2'd1;
                            phase = ST_START;
                        end
                    end
                    default: begin
                        phase = ST_IDLE;
                    end
                endcase
            end
            lv.clk_level = clk_line;
            lv.dio_level = dio_line;
            lv.busy_res = (phase != ST_IDLE) || finished;
            lv.done_res = finished;
            lv.ack_missing = nack;
            levels_due.push_back(lv);
        endfunction

        function void compare_field(string field, logic want, logic got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                fault_count++;
            end
        endfunction

        function void check_levels(t_out_item got);
            t_out_item want;
            if (levels_due.size() == 0) begin
                $error("output beat %p arrived with nothing expected", got);
                fault_count++;
                return;
            end
            want = levels_due.pop_front();
            compare_field("clk_level", want.clk_level, got.clk_level);
            compare_field("dio_level", want.dio_level, got.dio_level);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("ack_missing", want.ack_missing, got.ack_missing);
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_index = REG_BRIGHTNESS;
    logic [2:0] cfg_data = '0;

    // Switches for the sender gaps and the receiver stalls; both are dropped
    // together for one whole update so that a stretch runs at full rate.
    bit        gaps_on = 1'b1;
    logic      quiet = 1'b0;
    int        cycles = 0;

    t_link_tracker board;

    seven_segment_two_wire_sender i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // The receiver stalls at random, with a probability of thirty percent, unless told to be quiet.
    always @(posedge clk) begin
        if (!rst_n || quiet) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < 30);
        end
    end

    // Every output beat taken at this edge is checked against the oldest
    // expectation. Values seen here are those from before the edge, since all
    // testbench drives are nonblocking.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_levels(out_data);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Random content throughout, so that every field bit toggles even on the
    // beats where the block ignores it.
    function automatic t_in_item random_beat();
        t_in_item b;
        b = t_in_item'($bits(t_in_item)'({$urandom, $urandom}));
        return b;
    endfunction

    function automatic t_in_item tick_beat(logic sense);
        t_in_item b;
        b = random_beat();
        b.opcode = OP_TICK;
        b.dio_sense = sense;
        return b;
    endfunction

    // Offers one input beat, perhaps after a random gap, and returns at the
    // edge that accepts it. Valid is only lowered when a gap is taken, so a
    // back-to-back beat never sees valid dropped and raised in one step.
    task automatic push_beat(input t_in_item beat);
        if (gaps_on && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 30);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_beat(beat);
    endtask

    // Waits until every expected output beat has come back. Always advances at
    // least one edge so that valid is not lowered and raised in the same step.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.levels_due.size() != 0);
    endtask

    // Writes brightness and then the enable register back to back.
    task automatic load_display_setup(input logic [2:0] level,
                                      input logic [2:0] enable_word);
        cfg_valid <= 1'b1;
        cfg_index <= REG_BRIGHTNESS;
        cfg_data <= level;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_register(REG_BRIGHTNESS, level);
        cfg_index <= REG_ENABLE;
        cfg_data <= enable_word;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_register(REG_ENABLE, enable_word);
        cfg_valid <= 1'b0;
    endtask

    // Sends a begin beat and then ticks until the tracked sequence falls idle.
    // The display's answer in each acknowledge slot follows the chosen style,
    // and a stray begin is slipped in now and then to show it is ignored.
    task automatic run_update(input t_in_item cmd, input t_ack_style style,
                              input int intrude_pct);
        t_in_item b;
        logic     sense;
        cmd.opcode = OP_BEGIN;
        push_beat(cmd);
        while (board.busy()) begin
            if ($urandom_range(99) < intrude_pct) begin
                b = random_beat();
                b.opcode = OP_BEGIN;
                push_beat(b);
            end
            case (style)
                ACK_ALWAYS: sense = 1'b0;
                ACK_NEVER:  sense = 1'b1;
                ACK_RANDOM: sense = 1'($urandom_range(1));
                default:    sense = ($urandom_range(49) == 0);
            endcase
            push_beat(tick_beat(sense));
        end
    endtask

    initial begin
        t_in_item cmd;
        int       round;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ticks while idle must leave both lines high and report not busy.
        push_beat(tick_beat(1'b1));
        push_beat(tick_beat(1'b0));

        // Zero count with every operand at its low end: frame two carries
        // just the address byte. Register defaults are still in force.
        cmd = '0;
        run_update(cmd, ACK_ALWAYS, 0);
        push_beat(tick_beat(1'b0));

        // Everything at the top: the count saturates, the position is the
        // last digit, and the display never answers, so the missed
        // acknowledge flag must rise and still hold on the idle tick after.
        settle();
        load_display_setup(3'd0, 3'd0);
        cmd.digit0_segments = 8'hFF;
        cmd.digit1_segments = 8'hFF;
        cmd.digit2_segments = 8'hFF;
        cmd.digit3_segments = 8'hFF;
        cmd.digit_count = 3'd7;
        cmd.start_digit = 2'd3;
        cmd.dio_sense = 1'b1;
        run_update(cmd, ACK_NEVER, 3);
        push_beat(tick_beat(1'b1));

        // Full four-byte frame with walking patterns; enable written with its
        // upper data bits set but the on bit clear.
        settle();
        load_display_setup(3'd7, 3'd6);
        cmd.digit0_segments = 8'h01;
        cmd.digit1_segments = 8'h80;
        cmd.digit2_segments = 8'h55;
        cmd.digit3_segments = 8'hAA;
        cmd.digit_count = 3'd4;
        cmd.start_digit = 2'd2;
        run_update(cmd, ACK_RANDOM, 5);

        // Single byte, display on at the lowest brightness.
        settle();
        load_display_setup(3'd0, 3'd1);
        cmd = random_beat();
        cmd.digit_count = 3'd1;
        cmd.start_digit = 2'd1;
        run_update(cmd, ACK_MOSTLY, 0);

        // Random updates until enough live beats have gone through. The first
        // round runs with no gaps and no stalls at all.
        round = 0;
        while (board.useful_beats < BEAT_GOAL) begin
            if ($urandom_range(2) == 0) begin
                settle();
                load_display_setup(3'($urandom_range(7)), 3'($urandom_range(7)));
            end
            gaps_on = (round != 0);
            quiet <= (round == 0);
            repeat ($urandom_range(3)) push_beat(tick_beat(1'($urandom_range(1))));
            cmd = random_beat();
            if ($urandom_range(3) != 0) begin
                cmd.digit_count = 3'($urandom_range(4));
            end
            run_update(cmd, t_ack_style'($urandom_range(3)),
                       ($urandom_range(1) != 0) ? 2 : 0);
            round++;
        end

        settle();
        repeat (4) @(posedge clk);
        $display("Run covered %0d live beats and %0d ignored beats over %0d updates,",
                 board.useful_beats, board.ignored_beats, board.updates_done);
        $display("%0d of which saw a missed acknowledge; %0d mismatches logged.",
                 board.nack_updates, board.fault_count);
        if (board.fault_count == 0 && board.levels_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sstws_pkg.sv
rtl/seven_segment_two_wire_sender.sv
tb/testbench.sv
